/* hdl/vqdm_pkg.sv */
// Types, constants and a helper function shared by the descriptor manager modules.
// No dependencies.
package vqdm_pkg;

  localparam int unsigned QueueSize = 64;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned SizeW     = 7;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_DONE = 2'd1,
    REQ_POP  = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_REJECTED = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic complete;
    logic pop_refuse;
    logic misc;
    logic ur_read;
    logic walk_load;
    logic walk_step;
    logic finish;
    logic emit_load;
    logic emit_pop;
    logic emit_step;
    logic push_decide;
    logic push_write;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_e req;
    logic pos_zero;
    logic free_lt_n;
    logic used_empty;
    logic walk_end;
    logic reject_next;
  } sts_t;

  // Link held by a slot that has not been written since the last rebuild.
  function automatic logic [IdxW-1:0] default_link(logic [IdxW-1:0] i, logic [SizeW-1:0] size);
    logic [SizeW-1:0] nx;
    nx = {1'b0, i} + SizeW'(1);
    if (nx >= size) begin
      return '0;
    end else begin
      return nx[IdxW-1:0];
    end
  endfunction

endpackage

/* hdl/vqdm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vqdm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/vqdm_ctrl.sv */
// Controller state machine of the descriptor manager.
// Depends on vqdm_pkg for the command and status structs.
module vqdm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  vqdm_pkg::sts_t sts_i,
  output vqdm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_RCHK, S_UR, S_WALK, S_EMIT, S_PDEC, S_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.req)
          vqdm_pkg::REQ_PUSH: begin
            state_d = (sts_i.pos_zero && sts_i.free_lt_n) ? S_RCHK : S_PDEC;
          end
          vqdm_pkg::REQ_DONE: begin
            cmd_o.complete = 1'b1;
            state_d        = S_IDLE;
          end
          vqdm_pkg::REQ_POP: begin
            if (!sts_i.pos_zero || sts_i.used_empty) begin
              cmd_o.pop_refuse = 1'b1;
              state_d          = S_IDLE;
            end else begin
              cmd_o.ur_read = 1'b1;
              state_d       = S_UR;
            end
          end
          default: begin
            cmd_o.misc = 1'b1;
            state_d    = S_IDLE;
          end
        endcase
      end
      S_RCHK: begin
        if (sts_i.used_empty) begin
          state_d = S_PDEC;
        end else begin
          cmd_o.ur_read = 1'b1;
          state_d       = S_UR;
        end
      end
      S_UR: begin
        cmd_o.walk_load = 1'b1;
        state_d         = S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_end) begin
          if (sts_i.req == vqdm_pkg::REQ_POP) begin
            cmd_o.emit_load = 1'b1;
            state_d         = S_EMIT;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = S_RCHK;
          end
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.emit_pop = 1'b1;
        if (sts_i.walk_end) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.emit_step = 1'b1;
        end
      end
      S_PDEC: begin
        cmd_o.push_decide = 1'b1;
        state_d           = sts_i.reject_next ? S_IDLE : S_PUSH;
      end
      S_PUSH: begin
        cmd_o.push_write = 1'b1;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

/* hdl/vqdm_dp.sv */
// Datapath of the descriptor manager: descriptor table, used ring, counters and result.
// Depends on vqdm_pkg and vqdm_ram.
module vqdm_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [6:0]     cfg_wdata_i,
  input  logic [1:0]     req_type_i,
  input  logic [63:0]    buf_addr_i,
  input  logic [31:0]    buf_len_i,
  input  logic           dev_write_i,
  input  logic [6:0]     chain_len_i,
  input  logic [5:0]     used_id_i,
  input  vqdm_pkg::cmd_t cmd_i,
  output vqdm_pkg::sts_t sts_o,
  output logic           done_o,
  output logic [1:0]     status_o,
  output logic [5:0]     desc_index_o,
  output logic [63:0]    out_addr_o,
  output logic [31:0]    out_len_o,
  output logic           out_write_o,
  output logic [5:0]     head_index_o,
  output logic [5:0]     avail_slot_o,
  output logic [6:0]     free_count_o,
  output logic           last_o
);

  localparam logic [6:0] FullSize = 7'(vqdm_pkg::QueueSize);

  logic [6:0]  size_q;
  logic [1:0]  req_q;
  logic [63:0] addr_q;
  logic [31:0] len_q;
  logic        wr_q;
  logic [6:0]  n_q, limit_q;
  logic [5:0]  uid_q;
  logic [63:0] valid_q;
  logic [15:0] used_wr_q, used_rd_q, avail_q;
  logic [5:0]  wpos_q, rpos_q, apos_q;
  logic [5:0]  free_head_q, chain_start_q, head_q, idx_q;
  logic [6:0]  free_total_q, chain_pos_q, cnt_q;
  logic [6:0]  pop_free_q;
  logic        rejecting_q;
  logic        rd_valid_q;
  logic [5:0]  rd_addr_q;

  logic        done_q, out_write_q, last_q;
  logic [1:0]  status_q;
  logic [5:0]  desc_q, head_out_q, aslot_q;
  logic [63:0] out_addr_q;
  logic [31:0] out_len_q;
  logic [6:0]  free_out_q;

  logic [95:0] data_rdata;
  logic [7:0]  meta_rdata, meta_eff, meta_wdata;
  logic [5:0]  ur_rdata, raddr, meta_waddr;
  logic        re, meta_we, data_we, ur_we;
  logic [5:0]  link_cur;
  logic        next_cur;
  logic        is_last, rej_nx, used_full;
  logic [1:0]  st_dec;
  logic [7:0]  free_sum;
  logic [6:0]  free_sat;
  logic [6:0]  cfg_size;
  logic [6:0]  n_in;

  assign meta_eff = rd_valid_q ? meta_rdata
                  : {2'b00, vqdm_pkg::default_link(rd_addr_q, size_q)};
  assign link_cur = meta_eff[5:0];
  assign next_cur = meta_eff[6];

  assign is_last   = ({1'b0, chain_pos_q} + 8'd1) >= {1'b0, n_q};
  assign used_full = (used_wr_q - used_rd_q) >= {9'd0, size_q};
  assign free_sum  = {1'b0, free_total_q} + {1'b0, cnt_q} + 8'd1;
  assign free_sat  = (free_sum > {1'b0, size_q}) ? size_q : free_sum[6:0];
  assign n_in      = (chain_len_i == 7'd0) ? 7'd1 : chain_len_i;

  always_comb begin
    if (cfg_wdata_i < 7'd2) begin
      cfg_size = 7'd2;
    end else if (cfg_wdata_i > FullSize) begin
      cfg_size = FullSize;
    end else begin
      cfg_size = cfg_wdata_i;
    end
  end

  always_comb begin
    if (chain_pos_q == 7'd0) begin
      rej_nx = free_total_q < n_q;
      st_dec = rej_nx ? vqdm_pkg::ST_NOSPACE : vqdm_pkg::ST_OK;
    end else if (!rejecting_q && free_total_q == 7'd0) begin
      rej_nx = 1'b1;
      st_dec = vqdm_pkg::ST_NOSPACE;
    end else begin
      rej_nx = rejecting_q;
      st_dec = rejecting_q ? vqdm_pkg::ST_REJECTED : vqdm_pkg::ST_OK;
    end
  end

  always_comb begin
    re    = 1'b1;
    raddr = free_head_q;
    priority if (cmd_i.walk_load) begin
      raddr = ur_rdata;
    end else if (cmd_i.walk_step || cmd_i.emit_step) begin
      raddr = link_cur;
    end else if (cmd_i.emit_load) begin
      raddr = head_q;
    end else if (cmd_i.push_decide) begin
      raddr = free_head_q;
    end else begin
      re = 1'b0;
    end
  end

  always_comb begin
    meta_we    = cmd_i.finish || cmd_i.push_write;
    meta_waddr = cmd_i.finish ? idx_q : free_head_q;
    meta_wdata = cmd_i.finish ? {meta_eff[7:6], free_head_q}
               : {wr_q, !is_last, is_last ? 6'd0 : link_cur};
  end

  assign data_we = cmd_i.push_write;
  assign ur_we   = cmd_i.complete && !used_full;

  vqdm_ram #(.Width(96), .Depth(vqdm_pkg::QueueSize)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (free_head_q),
    .wdata_i ({addr_q, len_q}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (data_rdata)
  );

  vqdm_ram #(.Width(8), .Depth(vqdm_pkg::QueueSize)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (meta_rdata)
  );

  vqdm_ram #(.Width(6), .Depth(vqdm_pkg::QueueSize)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (ur_we),
    .waddr_i (wpos_q),
    .wdata_i (uid_q),
    .re_i    (cmd_i.ur_read),
    .raddr_i (rpos_q),
    .rdata_o (ur_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q        <= FullSize;
      valid_q       <= '0;
      used_wr_q     <= '0;
      used_rd_q     <= '0;
      avail_q       <= '0;
      wpos_q        <= '0;
      rpos_q        <= '0;
      apos_q        <= '0;
      free_head_q   <= '0;
      free_total_q  <= FullSize;
      chain_pos_q   <= '0;
      chain_start_q <= '0;
      rejecting_q   <= 1'b0;
      rd_valid_q    <= 1'b0;
      done_q        <= 1'b0;
    end else if (cfg_we_i) begin
      size_q        <= cfg_size;
      valid_q       <= '0;
      used_wr_q     <= '0;
      used_rd_q     <= '0;
      avail_q       <= '0;
      wpos_q        <= '0;
      rpos_q        <= '0;
      apos_q        <= '0;
      free_head_q   <= '0;
      free_total_q  <= cfg_size;
      chain_pos_q   <= '0;
      chain_start_q <= '0;
      rejecting_q   <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      done_q <= cmd_i.complete || cmd_i.pop_refuse || cmd_i.misc || cmd_i.emit_pop
             || cmd_i.push_write || (cmd_i.push_decide && rej_nx);
      if (re) begin
        rd_valid_q <= valid_q[raddr];
      end
      if (meta_we) begin
        valid_q[meta_waddr] <= 1'b1;
      end
      if (ur_we) begin
        used_wr_q <= used_wr_q + 16'd1;
        wpos_q    <= (used_wr_q == 16'hFFFF || {1'b0, wpos_q} + 7'd1 == size_q)
                   ? 6'd0 : wpos_q + 6'd1;
      end
      if (cmd_i.finish) begin
        free_head_q  <= head_q;
        free_total_q <= free_sat;
        used_rd_q    <= used_rd_q + 16'd1;
        rpos_q       <= (used_rd_q == 16'hFFFF || {1'b0, rpos_q} + 7'd1 == size_q)
                      ? 6'd0 : rpos_q + 6'd1;
      end
      if (cmd_i.push_decide) begin
        if (chain_pos_q == 7'd0) begin
          chain_start_q <= free_head_q;
        end
        if (rej_nx) begin
          chain_pos_q <= is_last ? 7'd0 : chain_pos_q + 7'd1;
          rejecting_q <= is_last ? 1'b0 : 1'b1;
        end else begin
          rejecting_q <= 1'b0;
        end
      end
      if (cmd_i.push_write) begin
        free_head_q  <= link_cur;
        free_total_q <= free_total_q - 7'd1;
        chain_pos_q  <= is_last ? 7'd0 : chain_pos_q + 7'd1;
        if (is_last) begin
          avail_q <= avail_q + 16'd1;
          apos_q  <= (avail_q == 16'hFFFF || {1'b0, apos_q} + 7'd1 == size_q)
                   ? 6'd0 : apos_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_addr_q <= raddr;
    end
    if (cmd_i.latch) begin
      req_q   <= req_type_i;
      addr_q  <= buf_addr_i;
      len_q   <= buf_len_i;
      wr_q    <= dev_write_i;
      n_q     <= n_in;
      uid_q   <= used_id_i;
      limit_q <= (req_type_i == vqdm_pkg::REQ_POP && n_in < size_q) ? n_in : size_q;
    end
    if (cmd_i.walk_load) begin
      head_q <= ur_rdata;
      idx_q  <= ur_rdata;
      cnt_q  <= '0;
    end
    if (cmd_i.walk_step || cmd_i.emit_step) begin
      idx_q <= link_cur;
      cnt_q <= cnt_q + 7'd1;
    end
    if (cmd_i.emit_load) begin
      idx_q      <= head_q;
      cnt_q      <= '0;
      pop_free_q <= free_sat;
    end

    status_q    <= vqdm_pkg::ST_OK;
    desc_q      <= '0;
    out_addr_q  <= '0;
    out_len_q   <= '0;
    out_write_q <= 1'b0;
    head_out_q  <= '0;
    aslot_q     <= '0;
    free_out_q  <= free_total_q;
    last_q      <= 1'b1;
    if (cmd_i.complete) begin
      status_q <= used_full ? vqdm_pkg::ST_NOSPACE : vqdm_pkg::ST_OK;
      desc_q   <= uid_q;
    end
    if (cmd_i.pop_refuse) begin
      status_q <= vqdm_pkg::ST_EMPTY;
    end
    if (cmd_i.push_decide) begin
      status_q <= st_dec;
    end
    if (cmd_i.push_write) begin
      desc_q     <= free_head_q;
      free_out_q <= free_total_q - 7'd1;
      if (is_last) begin
        head_out_q <= chain_start_q;
        aslot_q    <= apos_q;
      end
    end
    if (cmd_i.emit_pop) begin
      desc_q      <= idx_q;
      out_addr_q  <= data_rdata[95:32];
      out_len_q   <= data_rdata[31:0];
      out_write_q <= meta_eff[7];
      free_out_q  <= pop_free_q;
      last_q      <= sts_o.walk_end;
    end
  end

  assign sts_o.req         = vqdm_pkg::req_e'(req_q);
  assign sts_o.pos_zero    = (chain_pos_q == 7'd0);
  assign sts_o.free_lt_n   = free_total_q < n_q;
  assign sts_o.used_empty  = (used_rd_q == used_wr_q);
  assign sts_o.walk_end    = (cnt_q + 7'd1 >= limit_q) || !next_cur;
  assign sts_o.reject_next = rej_nx;

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign desc_index_o = desc_q;
  assign out_addr_o   = out_addr_q;
  assign out_len_o    = out_len_q;
  assign out_write_o  = out_write_q;
  assign head_index_o = head_out_q;
  assign avail_slot_o = aslot_q;
  assign free_count_o = free_out_q;
  assign last_o       = last_q;

endmodule

/* hdl/virtqueue_descriptor_manager.sv */
// Top level of the split-virtqueue descriptor manager.
// Depends on vqdm_pkg, vqdm_ctrl and vqdm_dp.
// Completion, type-3 and refused pops finish from dispatch; a push may first reclaim
// used chains when short of free descriptors; a pop walks a used chain, then emits its descriptors.
// One item is in work at a time; the chain walks through the table RAM set the rate.
// Results are one-cycle strobes on done_o that the receiver cannot stall.
// Reset (and any write of active_size) restores the full free list and empty rings.
module virtqueue_descriptor_manager (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] buf_addr_i,
  input  logic [31:0] buf_len_i,
  input  logic        dev_write_i,
  input  logic [6:0]  chain_len_i,
  input  logic [5:0]  used_id_i,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [5:0]  desc_index_o,
  output logic [63:0] out_addr_o,
  output logic [31:0] out_len_o,
  output logic        out_write_o,
  output logic [5:0]  head_index_o,
  output logic [5:0]  avail_slot_o,
  output logic [6:0]  free_count_o,
  output logic        last_o
);

  vqdm_pkg::cmd_t cmd;
  vqdm_pkg::sts_t sts;

  vqdm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  vqdm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .buf_addr_i   (buf_addr_i),
    .buf_len_i    (buf_len_i),
    .dev_write_i  (dev_write_i),
    .chain_len_i  (chain_len_i),
    .used_id_i    (used_id_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .done_o       (done_o),
    .status_o     (status_o),
    .desc_index_o (desc_index_o),
    .out_addr_o   (out_addr_o),
    .out_len_o    (out_len_o),
    .out_write_o  (out_write_o),
    .head_index_o (head_index_o),
    .avail_slot_o (avail_slot_o),
    .free_count_o (free_count_o),
    .last_o       (last_o)
  );

endmodule
